[rtl/chr_pkg.sv]
`timescale 1ns / 1ps
// chr_pkg: shared sizes, op codes, payload structs and memory request structs
// for the command history ring. No dependencies.
package chr_pkg;

  // ring of 16-bit words, size must stay a power of two (pointers wrap by truncation)
  localparam int RING_WORDS = 2048;
  localparam int RING_AW    = $clog2(RING_WORDS);
  localparam int WORD_W     = 16;
  localparam int WORD_BYTES = WORD_W / 8;

  // staging line, held two bytes per word
  localparam int LINE_BYTES = 512;
  localparam int LINE_WORDS = LINE_BYTES / WORD_BYTES;
  localparam int LINE_AW    = $clog2(LINE_WORDS);
  localparam int LEN_W      = $clog2(LINE_BYTES) + 1;

  // record size is (len + 5) / 2 words, tail to head skip is (len + 3) / 2
  localparam int REC_EXTRA  = 5;
  localparam int TAIL_SKIP  = 3;

  // op codes
  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_COMMIT = 3'd1;
  localparam logic [2:0] OP_PREV   = 3'd2;
  localparam logic [2:0] OP_NEXT   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [8:0] byte_index;
    logic [7:0] byte_value;
    logic [8:0] cmd_length;
  } cmd_t;

  typedef struct packed {
    logic       stored;
    logic [7:0] dropped_count;
    logic       recalled;
    logic [8:0] recalled_length;
    logic [7:0] read_byte;
  } rsp_t;

  // ring memory port request
  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
    logic               re;
    logic [RING_AW-1:0] raddr;
  } ring_req_t;

  // staging memory port request, byte lanes
  typedef struct packed {
    logic                  we;
    logic [WORD_BYTES-1:0] be;
    logic [LINE_AW-1:0]    waddr;
    logic [WORD_W-1:0]     wdata;
    logic                  re;
    logic [LINE_AW-1:0]    raddr;
  } stg_req_t;

  // (len + extra) / 2 taken to ring pointer width
  function automatic logic [RING_AW-1:0] half_up(input logic [WORD_W-1:0] len,
                                                 input logic [2:0] extra);
    logic [WORD_W:0] sum;
    sum = {1'b0, len} + (WORD_W + 1)'(extra);
    return sum[RING_AW:1];
  endfunction

endpackage

[rtl/chr_ram.sv]
`timescale 1ns / 1ps
// chr_ram: simple dual port synchronous RAM with byte lane write enables
// and registered read data. No dependencies.
module chr_ram #(
  parameter int ADDR_W = 8,
  parameter int LANES  = 2
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [LANES-1:0]     be,
  input  logic [ADDR_W-1:0]    waddr,
  input  logic [LANES*8-1:0]   wdata,
  input  logic                 re,
  input  logic [ADDR_W-1:0]    raddr,
  output logic [LANES*8-1:0]   rdata
);

  logic [LANES*8-1:0] mem [2**ADDR_W];

  // byte lane writes
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (we && be[i]) begin
        mem[waddr][i*8 +: 8] <= wdata[i*8 +: 8];
      end
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/chr_seq.sv]
`timescale 1ns / 1ps
// chr_seq: sequencer for the command history ring; holds the ring pointers and
// walks records through the ring and staging memories. Depends on chr_pkg.
module chr_seq import chr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              res_valid,
  output rsp_t              res,
  input  logic              res_take,
  output ring_req_t         ring_req,
  input  logic [WORD_W-1:0] ring_rdata,
  output stg_req_t          stg_req,
  input  logic [WORD_W-1:0] stg_rdata
);

  localparam int FREE_W = RING_AW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_C_LAST, S_C_CMP, S_D_CHK, S_D_RD, S_W_DATA, S_W_TAIL,
    S_P_TAIL, S_N_HEAD, S_CP_HEAD, S_CP_DATA, S_R_HEAD, S_R_DATA, S_DONE
  } state_t;

  state_t             state;
  logic [8:0]         bidx;
  logic [LEN_W-1:0]   clen;
  logic [RING_AW-1:0] oldest;
  logic [RING_AW-1:0] next_free;
  logic [RING_AW-1:0] recall;
  logic [RING_AW-1:0] rbase;
  logic [LINE_AW-1:0] wcnt;
  logic [LINE_AW-1:0] wlast;
  logic               hi_last;

  logic               accept;
  logic               empty;
  logic [LEN_W-1:0]   clen_in;
  logic [RING_AW-1:0] last_ptr;
  logic [LEN_W:0]     clen_up;
  logic [LEN_W-1:0]   nwords;
  logic [LEN_W:0]     need_sum;
  logic [LEN_W-1:0]   need;
  logic [RING_AW-1:0] occ;
  logic               need_drop;
  logic [LEN_W-1:0]   cap;
  logic [LEN_W:0]     cap_up;
  logic [LEN_W-1:0]   nwc;
  logic               hi_ok;
  logic               at_last;
  logic [LINE_AW-1:0] wcnt_inc;
  logic [RING_AW-1:0] newr_prev;
  logic [RING_AW-1:0] newr_next;
  logic [RING_AW-1:0] tail_ptr;
  logic               word_match;

  assign accept    = cmd_valid && cmd_ready;
  assign cmd_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign empty     = (oldest == next_free);

  // commit length, saturated to the line size
  assign clen_in = (LEN_W'(cmd.cmd_length) > LEN_W'(LINE_BYTES)) ?
                   LEN_W'(LINE_BYTES) : LEN_W'(cmd.cmd_length);

  // record geometry of the staged line
  assign last_ptr = next_free - 1'b1;
  assign clen_up  = {1'b0, clen} + 1'b1;
  assign nwords   = clen_up[LEN_W:1];
  assign need_sum = {1'b0, clen} + (LEN_W + 1)'(REC_EXTRA);
  assign need     = need_sum[LEN_W:1];
  assign occ      = next_free - oldest;
  assign need_drop = !empty &&
    ((FREE_W'(need) + FREE_W'(occ) + FREE_W'(1)) > FREE_W'(RING_WORDS));
  assign tail_ptr = rbase + RING_AW'(nwords);

  // geometry of a recalled record, length word on the read port
  assign cap    = (ring_rdata > WORD_W'(LINE_BYTES)) ?
                  LEN_W'(LINE_BYTES) : ring_rdata[LEN_W-1:0];
  assign cap_up = {1'b0, cap} + 1'b1;
  assign nwc    = cap_up[LEN_W:1];

  assign newr_prev = recall - 1'b1 - half_up(ring_rdata, 3'(TAIL_SKIP));
  assign newr_next = recall + half_up(ring_rdata, 3'(REC_EXTRA));

  // word loop bookkeeping
  assign at_last  = (wcnt == wlast);
  assign hi_ok    = !at_last || hi_last;
  assign wcnt_inc = wcnt + 1'b1;

  // stored word against staged bytes
  assign word_match = (ring_rdata[7:0] == stg_rdata[7:0]) &&
                      (!hi_ok || (ring_rdata[15:8] == stg_rdata[15:8]));

  // memory requests
  always_comb begin
    ring_req = '0;
    stg_req  = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_LOAD: begin
              stg_req.we    = (LEN_W'(cmd.byte_index) < LEN_W'(LINE_BYTES));
              stg_req.be    = cmd.byte_index[0] ? 2'b10 : 2'b01;
              stg_req.waddr = cmd.byte_index[LINE_AW:1];
              stg_req.wdata = {cmd.byte_value, cmd.byte_value};
            end
            OP_COMMIT: begin
              ring_req.re    = !empty;
              ring_req.raddr = last_ptr;
            end
            OP_PREV: begin
              ring_req.re    = (recall != oldest);
              ring_req.raddr = recall - 1'b1;
            end
            OP_NEXT, OP_READ: begin
              ring_req.re    = (recall != next_free);
              ring_req.raddr = recall;
            end
            default: ;
          endcase
        end
      end
      S_C_LAST: begin
        ring_req.re    = (ring_rdata == WORD_W'(clen)) && (clen != '0);
        ring_req.raddr = last_ptr - RING_AW'(nwords);
        stg_req.re     = ring_req.re;
        stg_req.raddr  = '0;
      end
      S_C_CMP: begin
        ring_req.re    = word_match && !at_last;
        ring_req.raddr = rbase + RING_AW'(wcnt_inc);
        stg_req.re     = ring_req.re;
        stg_req.raddr  = wcnt_inc;
      end
      S_D_CHK: begin
        if (need_drop) begin
          ring_req.re    = 1'b1;
          ring_req.raddr = oldest;
        end else begin
          ring_req.we    = 1'b1;
          ring_req.waddr = next_free;
          ring_req.wdata = WORD_W'(clen);
          stg_req.re     = 1'b1;
          stg_req.raddr  = '0;
        end
      end
      S_W_DATA: begin
        ring_req.we    = 1'b1;
        ring_req.waddr = rbase + RING_AW'(wcnt);
        ring_req.wdata = {(hi_ok ? stg_rdata[15:8] : 8'h00), stg_rdata[7:0]};
        stg_req.re     = !at_last;
        stg_req.raddr  = wcnt_inc;
      end
      S_W_TAIL: begin
        ring_req.we    = 1'b1;
        ring_req.waddr = tail_ptr;
        ring_req.wdata = WORD_W'(clen);
      end
      S_P_TAIL: begin
        ring_req.re    = 1'b1;
        ring_req.raddr = newr_prev;
      end
      S_N_HEAD: begin
        ring_req.re    = (newr_next != next_free);
        ring_req.raddr = newr_next;
      end
      S_CP_HEAD: begin
        ring_req.re    = (ring_rdata != '0);
        ring_req.raddr = recall + 1'b1;
      end
      S_CP_DATA: begin
        stg_req.we     = 1'b1;
        stg_req.be     = {hi_ok, 1'b1};
        stg_req.waddr  = wcnt;
        stg_req.wdata  = ring_rdata;
        ring_req.re    = !at_last;
        ring_req.raddr = rbase + RING_AW'(wcnt_inc);
      end
      S_R_HEAD: begin
        ring_req.re    = (WORD_W'(bidx) < ring_rdata);
        ring_req.raddr = recall + 1'b1 + RING_AW'(bidx[8:1]);
      end
      default: ;
    endcase
  end

  // state, pointers and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      next_free <= '0;
      recall    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            res  <= '0;
            bidx <= cmd.byte_index;
            clen <= clen_in;
            case (cmd.op)
              OP_COMMIT: state <= empty ? S_D_CHK : S_C_LAST;
              OP_PREV:   state <= (recall != oldest) ? S_P_TAIL : S_DONE;
              OP_NEXT:   state <= (recall != next_free) ? S_N_HEAD : S_DONE;
              OP_READ:   state <= (recall != next_free) ? S_R_HEAD : S_DONE;
              default:   state <= S_DONE;
            endcase
          end
        end
        // newest length word against the staged length
        S_C_LAST: begin
          if (ring_rdata != WORD_W'(clen)) begin
            state <= S_D_CHK;
          end else if (clen == '0) begin
            recall <= next_free;
            state  <= S_DONE;
          end else begin
            rbase   <= last_ptr - RING_AW'(nwords);
            wcnt    <= '0;
            wlast   <= LINE_AW'(nwords - 1'b1);
            hi_last <= !clen[0];
            state   <= S_C_CMP;
          end
        end
        // one word compared per cycle
        S_C_CMP: begin
          if (!word_match) begin
            state <= S_D_CHK;
          end else if (at_last) begin
            recall <= next_free;
            state  <= S_DONE;
          end else begin
            wcnt <= wcnt_inc;
          end
        end
        // drop oldest records until the new one fits
        S_D_CHK: begin
          if (need_drop) begin
            state <= S_D_RD;
          end else begin
            rbase   <= next_free + 1'b1;
            wcnt    <= '0;
            wlast   <= LINE_AW'(nwords - 1'b1);
            hi_last <= !clen[0];
            state   <= (nwords == '0) ? S_W_TAIL : S_W_DATA;
          end
        end
        S_D_RD: begin
          oldest <= oldest + half_up(ring_rdata, 3'(REC_EXTRA));
          if (res.dropped_count != 8'hFF) begin
            res.dropped_count <= res.dropped_count + 1'b1;
          end
          state <= S_D_CHK;
        end
        S_W_DATA: begin
          if (at_last) begin
            state <= S_W_TAIL;
          end else begin
            wcnt <= wcnt_inc;
          end
        end
        S_W_TAIL: begin
          next_free  <= tail_ptr + 1'b1;
          recall     <= tail_ptr + 1'b1;
          res.stored <= 1'b1;
          state      <= S_DONE;
        end
        // recall moves
        S_P_TAIL: begin
          recall       <= newr_prev;
          res.recalled <= 1'b1;
          state        <= S_CP_HEAD;
        end
        S_N_HEAD: begin
          recall       <= newr_next;
          res.recalled <= 1'b1;
          state        <= (newr_next != next_free) ? S_CP_HEAD : S_DONE;
        end
        S_CP_HEAD: begin
          res.recalled_length <= ring_rdata[8:0];
          if (ring_rdata == '0) begin
            state <= S_DONE;
          end else begin
            rbase   <= recall + 1'b1;
            wcnt    <= '0;
            wlast   <= LINE_AW'(nwc - 1'b1);
            hi_last <= !cap[0];
            state   <= S_CP_DATA;
          end
        end
        S_CP_DATA: begin
          if (at_last) begin
            state <= S_DONE;
          end else begin
            wcnt <= wcnt_inc;
          end
        end
        // byte read of the recalled record
        S_R_HEAD: begin
          state <= (WORD_W'(bidx) < ring_rdata) ? S_R_DATA : S_DONE;
        end
        S_R_DATA: begin
          res.read_byte <= bidx[0] ? ring_rdata[15:8] : ring_rdata[7:0];
          state         <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/command_history_ring.sv]
`timescale 1ns / 1ps
// command_history_ring: top level; sequencer, ring and staging memories and the
// result register. Depends on chr_pkg, chr_seq and chr_ram.
//
//   channel | signals                     | payload
//   cmd     | cmd_valid / cmd_ready       | cmd_t: op, byte_index, byte_value, cmd_length
//   rsp     | rsp_valid / rsp_ready       | rsp_t: stored, dropped_count, recalled,
//           |                             |        recalled_length, read_byte
//
// A recall takes longer with the recalled record's word count, a commit with the
// staged line's word count and the number of dropped records; the ring memory
// reads one word at a time and so sets the pace.
// Reset clears the pointers, the state and rsp_valid; the memories are not cleared.
// One command at a time; a new command is taken while the result register
// still holds the previous result, and the sequencer waits at its end for it.
module command_history_ring import chr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  ring_req_t         ring_req;
  stg_req_t          stg_req;
  logic [WORD_W-1:0] ring_rdata;
  logic [WORD_W-1:0] stg_rdata;
  logic              res_valid;
  rsp_t              res;
  logic              res_take;

  // result register can load when empty or draining
  assign res_take = !rsp_valid || rsp_ready;

  chr_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take),
    .ring_req   (ring_req),
    .ring_rdata (ring_rdata),
    .stg_req    (stg_req),
    .stg_rdata  (stg_rdata)
  );

  chr_ram #(.ADDR_W(RING_AW), .LANES(WORD_BYTES)) u_ring (
    .clk   (clk),
    .we    (ring_req.we),
    .be    ({WORD_BYTES{1'b1}}),
    .waddr (ring_req.waddr),
    .wdata (ring_req.wdata),
    .re    (ring_req.re),
    .raddr (ring_req.raddr),
    .rdata (ring_rdata)
  );

  chr_ram #(.ADDR_W(LINE_AW), .LANES(WORD_BYTES)) u_stage (
    .clk   (clk),
    .we    (stg_req.we),
    .be    (stg_req.be),
    .waddr (stg_req.waddr),
    .wdata (stg_req.wdata),
    .re    (stg_req.re),
    .raddr (stg_req.raddr),
    .rdata (stg_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (res_valid && res_take) begin
      rsp <= res;
    end
  end

endmodule

[rtl/chr_checker.sv]
`timescale 1ns / 1ps
// chr_checker: port level checks for command_history_ring, bound to the top
// level. Depends on chr_pkg.
module chr_checker import chr_pkg::*; (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // one command transfer at a time
  a_take_once: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken on consecutive cycles");

  // drops only happen on a commit that stores
  a_drop_store: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.dropped_count != 8'd0) |-> rsp.stored)
    else $error("records dropped without a store");

  // a recalled length comes with a recall
  a_len_recall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.recalled_length != 9'd0) |-> rsp.recalled)
    else $error("recalled length without recall");

  // a read byte stands alone in its result
  a_byte_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.read_byte != 8'd0) |->
      !rsp.stored && !rsp.recalled && (rsp.recalled_length == 9'd0))
    else $error("read byte mixed with other fields");

endmodule

bind command_history_ring chr_checker u_chk (.*);
